// ===== design/stt_pkg.sv =====
// ============================================================================
// Section timing table package
// Shared constants, command and status types for the section timing table.
// ============================================================================
package stt_pkg;

    localparam int ENTRIES_DEFAULT = 256;
    localparam int ID_W    = 32;
    localparam int TIME_W  = 32;
    localparam int SUM_W   = 40;
    localparam int PCT_W   = 15;
    localparam int PCT_FULL = 25600;
    localparam int PROD_W  = 47;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_END    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the request
        logic sum_clear;   // clear the sum accumulator
        logic sum_step;    // read next slot into sum
        logic probe_start; // set probe pointer to the home slot
        logic probe_step;  // examine current slot, advance
        logic apply;       // perform the operation on the found slot
        logic div_start;   // start the divider
        logic div_step;    // one restoring division step
        logic fail;        // table full result
    } stt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sum_done;
        logic probe_hit;
        logic probe_last;
        logic div_done;
        logic is_query;
        logic sum_zero;
    } stt_status_t;

endpackage

// ===== design/stt_ctrl.sv =====
// ============================================================================
// Section timing table controller
// Sequences sum, probe, update and division phases for one request.
// ============================================================================
module stt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  stt_pkg::stt_status_t status,
    output stt_pkg::stt_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SUM, ST_SUMW, ST_PROBE, ST_WAIT, ST_APPLY, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load      = 1'b1;
                    cmd.sum_clear = 1'b1;
                    state_next    = ST_SUM;
                end
            end
            ST_SUM: begin
                // The sum is only needed for a query.
                if (status.is_query && !status.sum_done) begin
                    cmd.sum_step = 1'b1;
                end else begin
                    state_next = ST_SUMW;
                end
            end
            ST_SUMW: begin
                cmd.probe_start = 1'b1;
                state_next      = ST_PROBE;
            end
            ST_PROBE: begin
                cmd.probe_step = 1'b1;
                state_next     = ST_WAIT;
            end
            ST_WAIT: begin
                if (status.probe_hit) begin
                    state_next = ST_APPLY;
                end else if (status.probe_last) begin
                    cmd.fail   = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PROBE;
                end
            end
            ST_APPLY: begin
                cmd.apply = 1'b1;
                if (status.is_query && !status.sum_zero) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.div_start = cmd.apply;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_one_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.sum_step, cmd.probe_step, cmd.apply, cmd.div_step}))
        else $error("controller issued overlapping commands");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("request accepted while busy");
    a_result_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

endmodule

// ===== design/stt_datapath.sv =====
// ============================================================================
// Section timing table datapath
// Slot memories, probe pointer, sum accumulator and a restoring divider.
// ============================================================================
module stt_datapath #(
    parameter int ENTRIES = stt_pkg::ENTRIES_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [1:0]                s_mode,
    input  logic [stt_pkg::ID_W-1:0]  s_section_id,
    input  logic [stt_pkg::TIME_W-1:0] s_now_time,
    input  stt_pkg::stt_cmd_t         cmd,
    output stt_pkg::stt_status_t      status,
    output logic                      m_ok,
    output logic [31:0]               m_section_total,
    output logic [stt_pkg::PCT_W-1:0] m_percent_q8
);

    localparam int IW = $clog2(ENTRIES);
    localparam int DIV_STEPS = stt_pkg::PROD_W;

    // Valid and timing flags in flip-flops; reset clears them at once.
    logic [ENTRIES-1:0] valid_reg, timing_reg;
    logic [31:0] id_mem    [ENTRIES];
    logic [31:0] start_mem [ENTRIES];
    logic [31:0] total_mem [ENTRIES];

    logic [1:0]  mode_reg;
    logic [31:0] sid_reg, now_reg;
    logic [IW:0] cnt_reg;
    logic [IW-1:0] ptr_reg, slot_reg;
    logic [IW:0] probes_reg;
    logic        rd_vld_reg, rd_tim_reg, hit_reg, sum_vld_reg;
    logic [31:0] rd_start_reg, rd_total_reg, sum_rd_reg;
    logic [stt_pkg::SUM_W-1:0] sum_reg;
    logic [stt_pkg::PROD_W-1:0] rem_reg, quo_reg, num_reg;
    logic [5:0]  div_cnt_reg;
    logic        ok_reg;
    logic [31:0] tot_out_reg;
    logic [IW-1:0] home;
    logic        sum_take;

    assign home = IW'(sid_reg[7:0] ^ sid_reg[15:8]);

    // A sum step is taken only while slots remain to be read.
    assign sum_take = cmd.sum_step && (cnt_reg != (IW+1)'(ENTRIES));

    assign status.sum_done   = (cnt_reg == (IW+1)'(ENTRIES)) && !sum_vld_reg;
    assign status.probe_hit  = hit_reg;
    assign status.probe_last = (probes_reg == (IW+1)'(ENTRIES));
    assign status.div_done   = (div_cnt_reg == 6'(DIV_STEPS));
    assign status.is_query   = (mode_reg == stt_pkg::MODE_QUERY);
    assign status.sum_zero   = (sum_reg == '0);

    logic [stt_pkg::PROD_W:0] trial;
    assign trial = {rem_reg[stt_pkg::PROD_W-2:0], num_reg[stt_pkg::PROD_W-1], 1'b0} >> 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            timing_reg <= '0;
        end else if (cmd.apply) begin
            // A free slot found by the probe is claimed, except by a remove.
            unique case (mode_reg)
                stt_pkg::MODE_START: begin
                    valid_reg[slot_reg]  <= 1'b1;
                    timing_reg[slot_reg] <= 1'b1;
                end
                stt_pkg::MODE_END: begin
                    valid_reg[slot_reg]  <= 1'b1;
                    timing_reg[slot_reg] <= 1'b0;
                end
                stt_pkg::MODE_REMOVE: valid_reg[slot_reg] <= 1'b0;
                default: begin
                    valid_reg[slot_reg] <= 1'b1;
                    if (!rd_vld_reg) timing_reg[slot_reg] <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_mode;
            sid_reg  <= s_section_id;
            now_reg  <= s_now_time;
        end
        // Sum phase: one slot read per cycle, accumulated in the cycle after its read.
        sum_vld_reg <= sum_take;
        if (cmd.sum_clear) begin
            cnt_reg <= '0;
            sum_reg <= '0;
        end else begin
            if (sum_take) begin
                sum_rd_reg  <= valid_reg[cnt_reg[IW-1:0]] ? total_mem[cnt_reg[IW-1:0]] : '0;
                cnt_reg     <= cnt_reg + 1'b1;
            end
            if (sum_vld_reg) sum_reg <= sum_reg + stt_pkg::SUM_W'(sum_rd_reg);
        end
        // Probe phase.
        if (cmd.probe_start) begin
            ptr_reg    <= home;
            probes_reg <= '0;
            hit_reg    <= 1'b0;
        end
        if (cmd.probe_step) begin
            rd_vld_reg   <= valid_reg[ptr_reg];
            rd_tim_reg   <= timing_reg[ptr_reg];
            rd_start_reg <= start_mem[ptr_reg];
            rd_total_reg <= total_mem[ptr_reg];
            hit_reg      <= !valid_reg[ptr_reg] || (id_mem[ptr_reg] == sid_reg);
            slot_reg     <= ptr_reg;
            ptr_reg      <= ptr_reg + 1'b1;
            probes_reg   <= probes_reg + 1'b1;
        end
        if (cmd.fail) begin
            ok_reg      <= 1'b0;
            tot_out_reg <= '0;
            quo_reg     <= '0;
        end
        if (cmd.apply) begin
            logic claim;
            logic tim;
            logic [31:0] tot;
            claim = !rd_vld_reg;
            tim   = claim ? 1'b0 : rd_tim_reg;
            tot   = claim ? 32'd0 : rd_total_reg;
            if (claim) id_mem[slot_reg] <= sid_reg;
            if ((mode_reg == stt_pkg::MODE_END) && tim) begin
                total_mem[slot_reg] <= tot + (now_reg - rd_start_reg);
            end else if (claim) begin
                total_mem[slot_reg] <= '0;
            end
            if ((mode_reg == stt_pkg::MODE_START) && !tim) start_mem[slot_reg] <= now_reg;
            ok_reg      <= (mode_reg == stt_pkg::MODE_START) ? !tim :
                           (mode_reg == stt_pkg::MODE_END)   ? tim  : 1'b1;
            tot_out_reg <= (mode_reg == stt_pkg::MODE_QUERY) ? tot : 32'd0;
            quo_reg     <= '0;
        end
        // Restoring division: one quotient bit per cycle.
        if (cmd.div_start) begin
            num_reg     <= stt_pkg::PROD_W'(rd_vld_reg ? rd_total_reg : 32'd0)
                           * stt_pkg::PROD_W'(stt_pkg::PCT_FULL);
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            if (trial >= (stt_pkg::PROD_W+1)'(sum_reg)) begin
                rem_reg <= stt_pkg::PROD_W'(trial - (stt_pkg::PROD_W+1)'(sum_reg));
                quo_reg <= {quo_reg[stt_pkg::PROD_W-2:0], 1'b1};
            end else begin
                rem_reg <= stt_pkg::PROD_W'(trial);
                quo_reg <= {quo_reg[stt_pkg::PROD_W-2:0], 1'b0};
            end
            num_reg     <= {num_reg[stt_pkg::PROD_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    assign m_ok            = ok_reg;
    assign m_section_total = tot_out_reg;
    assign m_percent_q8    = (quo_reg > stt_pkg::PROD_W'(stt_pkg::PCT_FULL))
                             ? stt_pkg::PCT_W'(stt_pkg::PCT_FULL)
                             : quo_reg[stt_pkg::PCT_W-1:0];

    a_probe_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.probe_step |-> (probes_reg < (IW+1)'(ENTRIES)))
        else $error("probe ran past the table size");
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (sum_reg != '0))
        else $error("division by a zero sum");
    a_sum_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |=> $stable(sum_reg))
        else $error("sum changed during division");

endmodule

// ===== design/section_timing_table.sv =====
// ============================================================================
// Section timing table
// Open-addressed table of timing sections with start, end, remove and query.
// ============================================================================
// Each request probes slots one at a time from the home slot, up to all
// slots of the table (256 by default); a query also sums the totals of all
// in-use slots and, when that sum is not zero, runs the restoring divider.
// One request is handled at a time; the next is taken once the result leaves.
// Reset clears all in-use and timing flags at once; no clearing pass is needed.
module section_timing_table #(
    parameter int ENTRIES = stt_pkg::ENTRIES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [31:0] s_section_id,
    input  logic [31:0] s_now_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [31:0] m_section_total,
    output logic [14:0] m_percent_q8
);

    // Command and status groups between the controller and the datapath.
    stt_pkg::stt_cmd_t    cmd;
    stt_pkg::stt_status_t status;

    // The controller owns the handshakes and phase sequencing.
    stt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the table and computes each request's result.
    stt_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_mode          (s_mode),
        .s_section_id    (s_section_id),
        .s_now_time      (s_now_time),
        .cmd             (cmd),
        .status          (status),
        .m_ok            (m_ok),
        .m_section_total (m_section_total),
        .m_percent_q8    (m_percent_q8)
    );

endmodule

// ===== verif/section_timing_table_test.sv =====
// ============================================================================
// Section timing table testbench
// Drives start, end, remove and query requests into the section timing table
// and checks every result against an in-bench model of the hashed table.
// ============================================================================
module section_timing_table_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 256;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic        ok;
        logic [31:0] total;
        logic [14:0] pct;
    } timing_result_t;

    // The scoreboard keeps its own copy of the table and a queue of the
    // results that accepted requests must produce, oldest first.
    class timing_scoreboard;
        bit          slot_used[NSLOT];
        bit          slot_running[NSLOT];
        logic [31:0] slot_id[NSLOT];
        logic [31:0] slot_start[NSLOT];
        logic [31:0] slot_total[NSLOT];
        timing_result_t pending_results[$];
        int mismatches;
        int checked;

        function void clear_table();
            for (int i = 0; i < NSLOT; i++) begin
                slot_used[i] = 0;
                slot_running[i] = 0;
                slot_total[i] = '0;
            end
        endfunction

        // Linear probe from the home slot; a missing ID claims the first
        // free slot. Returns -1 when the table is full.
        function int locate_section(logic [31:0] id);
            int home;
            int s;
            home = id[7:0] ^ id[15:8];
            for (int n = 0; n < NSLOT; n++) begin
                s = (home + n) % NSLOT;
                if (slot_used[s] && slot_id[s] == id) return s;
                if (!slot_used[s]) begin
                    slot_used[s] = 1;
                    slot_id[s] = id;
                    slot_total[s] = '0;
                    slot_running[s] = 0;
                    return s;
                end
            end
            return -1;
        endfunction

        function void note_request(logic [1:0] mode, logic [31:0] id, logic [31:0] now);
            timing_result_t r;
            logic [39:0] sum;
            logic [71:0] q;
            int s;
            r = '0;
            sum = '0;
            if (mode == stt_pkg::MODE_QUERY)
                for (int i = 0; i < NSLOT; i++)
                    if (slot_used[i]) sum += slot_total[i];
            s = locate_section(id);
            if (s >= 0) begin
                case (mode)
                    stt_pkg::MODE_START: begin
                        if (!slot_running[s]) begin
                            slot_running[s] = 1;
                            slot_start[s] = now;
                            r.ok = 1;
                        end
                    end
                    stt_pkg::MODE_END: begin
                        if (slot_running[s]) begin
                            slot_total[s] = slot_total[s] + (now - slot_start[s]);
                            slot_running[s] = 0;
                            r.ok = 1;
                        end
                    end
                    stt_pkg::MODE_REMOVE: begin
                        slot_used[s] = 0;
                        r.ok = 1;
                    end
                    default: begin
                        r.ok = 1;
                        r.total = slot_total[s];
                        if (sum != 0) begin
                            q = (72'(slot_total[s]) * stt_pkg::PCT_FULL) / sum;
                            r.pct = (q > stt_pkg::PCT_FULL) ? 15'(stt_pkg::PCT_FULL)
                                                            : q[14:0];
                        end
                    end
                endcase
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(timing_result_t got);
            timing_result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result ok=%0d total=%0d pct=%0d",
                             got.ok, got.total, got.pct);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected ok=%0d total=%0d pct=%0d, got ok=%0d total=%0d pct=%0d",
                             checked, want.ok, want.total, want.pct,
                             got.ok, got.total, got.pct);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_mode = stt_pkg::MODE_START;
    logic [31:0] s_section_id = '0;
    logic [31:0] s_now_time = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_ok;
    logic [31:0] m_section_total;
    logic [14:0] m_percent_q8;

    timing_scoreboard board = new();
    bit   quiet_phase = 0;       // no idling near the end of the run
    int   idle_cycles = 0;
    int   sent = 0;
    logic [31:0] clock_ms = 32'h0000_1000;
    logic [31:0] id_pool[16];

    section_timing_table dut (.*);

    always #5 aclk = ~aclk;

    // Watchdog: counts cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: sample at the clock edge, and stall in random bursts.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                board.check_result({m_ok, m_section_total, m_percent_q8});
        end
    end

    initial begin : result_ready_driver
        int burst;
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= 1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            if (!quiet_phase && $urandom_range(0, 2) == 0) begin
                burst = $urandom_range(1, 7);
                m_ready <= 0;
                repeat (burst) @(posedge aclk);
            end
        end
    end

    // Presents one request and holds it until it is accepted. The model is
    // updated at acceptance so that it sees requests in the block's order.
    // Valid drops only when an idle gap is inserted before the next request.
    task automatic send_request(logic [1:0] mode, logic [31:0] id, logic [31:0] now);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1;
        s_mode <= mode;
        s_section_id <= id;
        s_now_time <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(mode, id, now);
        sent++;
    endtask

    // A well-formed timing of one section: start, later end, sometimes query.
    task automatic timed_interval(logic [31:0] id);
        send_request(stt_pkg::MODE_START, id, clock_ms);
        clock_ms += $urandom_range(0, 5000);
        send_request(stt_pkg::MODE_END, id, clock_ms);
        if ($urandom_range(0, 2) == 0) send_request(stt_pkg::MODE_QUERY, id, clock_ms);
    endtask

    initial begin : stimulus
        logic [31:0] id;
        int pick;
        board.clear_table();
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part: extremes, all modes, start twice, end while idle,
        // wrap of the elapsed time, query with zero sum, colliding IDs.
        send_request(stt_pkg::MODE_QUERY, 32'h0, 32'h0);
        send_request(stt_pkg::MODE_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(stt_pkg::MODE_START, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_request(stt_pkg::MODE_START, 32'hFFFF_FFFF, 32'h0000_0005);
        send_request(stt_pkg::MODE_END, 32'hFFFF_FFFF, 32'h0000_0010);
        send_request(stt_pkg::MODE_QUERY, 32'hFFFF_FFFF, 32'h0);
        send_request(stt_pkg::MODE_START, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(stt_pkg::MODE_END, 32'h0000_0000, 32'h7FFF_FFFF);
        send_request(stt_pkg::MODE_QUERY, 32'h0000_0000, 32'h0);
        // These IDs share home slot 0 with the IDs above, so all three probe on.
        send_request(stt_pkg::MODE_START, 32'h0000_0101, 32'd100);
        send_request(stt_pkg::MODE_START, 32'h0001_0202, 32'd100);
        send_request(stt_pkg::MODE_START, 32'hABCD_0000, 32'd100);
        send_request(stt_pkg::MODE_END, 32'hABCD_0000, 32'd900);
        // Removing the first leaves a hole, so the third is claimed again.
        send_request(stt_pkg::MODE_REMOVE, 32'h0000_0101, 32'd0);
        send_request(stt_pkg::MODE_QUERY, 32'hABCD_0000, 32'd0);
        send_request(stt_pkg::MODE_REMOVE, 32'h5555_AAAA, 32'h5555_5555);
        send_request(stt_pkg::MODE_QUERY, 32'h1234_5678, 32'hAAAA_AAAA);

        // Fill the table completely so that further new IDs fail.
        for (int i = 0; i < 300; i++)
            send_request(stt_pkg::MODE_START, {16'($urandom_range(0, 65535)), i[15:0]},
                         $urandom);
        send_request(stt_pkg::MODE_QUERY, 32'hDEAD_BEEF, 32'd0);
        // Empty it again by removing the sections still in use, from the top
        // slot down so that earlier removals cut short no probe chain that does not wrap.
        for (int s = NSLOT - 1; s >= 0; s--)
            if (board.slot_used[s])
                send_request(stt_pkg::MODE_REMOVE, board.slot_id[s], $urandom);

        // Random part: mostly start/end pairs on a small pool of IDs,
        // six with adjacent home slots 0 to 5, mixed with noise.
        for (int i = 0; i < 16; i++)
            id_pool[i] = (i < 6) ? {16'($urandom_range(0, 65535)), 8'h33, 8'h33 ^ i[7:0]}
                                 : $urandom;
        while (sent < 950) begin
            if (sent > 850) quiet_phase = 1;
            id = id_pool[$urandom_range(0, 15)];
            pick = $urandom_range(0, 9);
            if (pick < 5) timed_interval(id);
            else if (pick == 5) send_request(stt_pkg::MODE_REMOVE, id, $urandom);
            else if (pick == 6) send_request(stt_pkg::MODE_QUERY, id, $urandom);
            else send_request(2'($urandom), (pick == 9) ? $urandom : id, $urandom);
        end
        s_valid <= 0;

        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("covered %0d requests with %0d results checked, including a full table",
                 sent, board.checked);
        if (board.mismatches == 0 && board.pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("simulation failed");
        end
        $finish;
    end
endmodule
